### src/nnss_pkg.sv
// Package for the name number-suffix splitter: payload structs, character
// constants and the case-folding helper. No dependencies.
`default_nettype none

package nnss_pkg;

  // Default bound on name length; names must be strictly shorter.
  parameter int unsigned MaxNameLen = 1024;

  localparam int unsigned PlainLenW = 10;
  localparam int unsigned SuffixW   = 32;

  localparam logic [7:0] CharUnderscore = 8'h5F;  // '_'
  localparam logic [7:0] CharZero       = 8'h30;  // '0'
  localparam logic [7:0] CharNine       = 8'h39;  // '9'
  localparam logic [7:0] CharUpperA     = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperZ     = 8'h5A;  // 'Z'
  localparam logic [7:0] CaseOffset     = 8'h20;

  localparam int unsigned NoneLen = 4;

  // "none", lower case
  localparam logic [7:0] NoneText [NoneLen] = '{8'h6E, 8'h6F, 8'h6E, 8'h65};

  // none_match code once the prefix can no longer spell "none"
  localparam logic [2:0] NoneMiss = 3'd7;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_t;

  typedef struct packed {
    logic [PlainLenW-1:0] plain_length;
    logic [SuffixW-1:0]   suffix_plus_one;
    logic                 is_none;
  } result_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/nnss_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is a parameter; used with the structs of nnss_pkg.
`default_nettype none

interface nnss_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### src/name_number_suffix_split_unit.sv
// Name number-suffix splitter, top level.
// Depends on nnss_pkg (types, constants) and nnss_stream_if (channels).
`default_nettype none

// The block takes a name one character per transaction on char_i, with last
// set on the final character, and gives one transaction on result_o per name.
// A trailing '_' followed by a run of decimal digits is split off when at
// least one character precedes the underscore, the run has no leading zero
// (a lone '0' is fine), and its value fits 32 bits and is not all ones.
// The result carries the plain-name length, the suffix value plus one (zero
// means no split) and whether the plain part spells "none" in any letter
// case. Throughput is one character per cycle, sustained without gaps while the result sink keeps up; the
// result reaches the output register in the cycle after the final character
// is taken. The per-character critical path is the digit accumulate (value
// times ten plus digit, 36 bits with carry-out for the overflow flag) feeding
// the split decision and the result register. A result waiting on a stalled
// sink blocks further characters only when it cannot be handed over in the
// same cycle. Names must be shorter than MaxNameLen; longer names saturate
// their lengths at MaxNameLen - 1, and plain_length keeps its low 10 bits.
module name_number_suffix_split_unit #(
  parameter int unsigned MaxNameLen = nnss_pkg::MaxNameLen
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  nnss_stream_if.sink   char_i,
  nnss_stream_if.source result_o
);

  localparam int unsigned CntW = $clog2(MaxNameLen);
  localparam logic [CntW-1:0] MaxIdx = CntW'(MaxNameLen - 1);
  localparam int unsigned AccW = nnss_pkg::SuffixW + 4;

  // run length only matters as zero, one or more than one
  typedef enum logic [1:0] {
    RunNone = 2'd0,
    RunOne  = 2'd1,
    RunMany = 2'd2
  } run_len_e;

  // ---------------------------------------------------------------------
  // Name state
  // ---------------------------------------------------------------------
  logic [CntW-1:0]                char_count_q, char_count_d;
  run_len_e                       run_len_q, run_len_d;
  logic [nnss_pkg::SuffixW-1:0]   run_value_q, run_value_d;
  logic                           run_ovf_q, run_ovf_d;
  logic                           run_lead_zero_q, run_lead_zero_d;
  logic                           run_follows_us_q, run_follows_us_d;
  logic                           prev_us_ok_q, prev_us_ok_d;
  logic [CntW-1:0]                us_index_q, us_index_d;
  logic [2:0]                     none_match_q, none_match_d;
  logic                           prefix_none_q, prefix_none_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  nnss_pkg::result_t              result_q, result_d;

  nnss_pkg::char_t                item;
  logic                           accept;
  logic                           is_digit;
  logic [3:0]                     digit;
  logic [AccW-1:0]                acc;
  logic [CntW-1:0]                total;
  logic                           split;
  logic [CntW-1:0]                plain;
  logic [CntW+nnss_pkg::PlainLenW-1:0] plain_ext;

  // New character taken whenever the output register is free or draining.
  assign char_i.ready = !out_valid_q || result_o.ready;
  assign accept       = char_i.valid && char_i.ready;
  assign item         = char_i.data;

  assign digit = item.character[3:0];
  // value * 10 + digit as (v << 3) + (v << 1) + d
  assign acc   = ({4'b0, run_value_q} << 3) + ({4'b0, run_value_q} << 1)
               + {{(AccW-4){1'b0}}, digit};
  assign total = (char_count_q == MaxIdx) ? MaxIdx : char_count_q + 1'b1;

  always_comb begin
    is_digit = 1'b0;
    if (item.character inside {[nnss_pkg::CharZero:nnss_pkg::CharNine]}) begin
      is_digit = 1'b1;
    end
  end

  // Per-character state update, before end-of-name handling.
  always_comb begin
    char_count_d     = total;
    run_len_d        = run_len_q;
    run_value_d      = run_value_q;
    run_ovf_d        = run_ovf_q;
    run_lead_zero_d  = run_lead_zero_q;
    run_follows_us_d = run_follows_us_q;
    prev_us_ok_d     = 1'b0;
    us_index_d       = us_index_q;
    none_match_d     = none_match_q;
    prefix_none_d    = prefix_none_q;

    // "none" prefix tracking over the first four characters
    if (char_count_q < CntW'(nnss_pkg::NoneLen)) begin
      if (none_match_q == 3'(char_count_q)
          && nnss_pkg::fold_lower(item.character)
             == nnss_pkg::NoneText[char_count_q[1:0]]) begin
        none_match_d = 3'(char_count_q) + 3'd1;
        if (none_match_d == 3'(nnss_pkg::NoneLen)) begin
          prefix_none_d = 1'b1;
        end
      end else begin
        none_match_d = nnss_pkg::NoneMiss;
      end
    end

    if (is_digit) begin
      if (run_len_q == RunNone) begin
        run_follows_us_d = prev_us_ok_q;
        run_lead_zero_d  = (digit == 4'd0);
        run_value_d      = {{(nnss_pkg::SuffixW-4){1'b0}}, digit};
        run_ovf_d        = 1'b0;
        run_len_d        = RunOne;
      end else begin
        if (acc[AccW-1:nnss_pkg::SuffixW] != 4'd0) begin
          run_ovf_d = 1'b1;
        end
        run_value_d = acc[nnss_pkg::SuffixW-1:0];
        run_len_d   = RunMany;
      end
    end else begin
      run_len_d        = RunNone;
      run_value_d      = '0;
      run_ovf_d        = 1'b0;
      run_lead_zero_d  = 1'b0;
      run_follows_us_d = 1'b0;
      if (item.character == nnss_pkg::CharUnderscore) begin
        prev_us_ok_d = (char_count_q != '0);
        us_index_d   = char_count_q;
      end
    end
  end

  // End-of-name decision on the updated state.
  always_comb begin
    split = (run_len_d != RunNone) && run_follows_us_d
         && !(run_len_d == RunMany && run_lead_zero_d)
         && !run_ovf_d && (run_value_d != '1);
    plain     = split ? us_index_d : total;
    plain_ext = {{nnss_pkg::PlainLenW{1'b0}}, plain};

    result_d.plain_length    = plain_ext[nnss_pkg::PlainLenW-1:0];
    result_d.suffix_plus_one = split ? run_value_d + 1'b1 : '0;
    result_d.is_none         = (plain == CntW'(nnss_pkg::NoneLen)) && prefix_none_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && item.last) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q     <= '0;
      run_len_q        <= RunNone;
      run_value_q      <= '0;
      run_ovf_q        <= 1'b0;
      run_lead_zero_q  <= 1'b0;
      run_follows_us_q <= 1'b0;
      prev_us_ok_q     <= 1'b0;
      us_index_q       <= '0;
      none_match_q     <= '0;
      prefix_none_q    <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (item.last) begin
          // name complete: start afresh
          char_count_q     <= '0;
          run_len_q        <= RunNone;
          run_value_q      <= '0;
          run_ovf_q        <= 1'b0;
          run_lead_zero_q  <= 1'b0;
          run_follows_us_q <= 1'b0;
          prev_us_ok_q     <= 1'b0;
          us_index_q       <= '0;
          none_match_q     <= '0;
          prefix_none_q    <= 1'b0;
        end else begin
          char_count_q     <= char_count_d;
          run_len_q        <= run_len_d;
          run_value_q      <= run_value_d;
          run_ovf_q        <= run_ovf_d;
          run_lead_zero_q  <= run_lead_zero_d;
          run_follows_us_q <= run_follows_us_d;
          prev_us_ok_q     <= prev_us_ok_d;
          us_index_q       <= us_index_d;
          none_match_q     <= none_match_d;
          prefix_none_q    <= prefix_none_d;
        end
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept && item.last) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = result_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item.last |=> out_valid_q)
    else $error("final character did not load a result");

  a_last_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item.last |=> char_count_q == '0 && run_len_q == RunNone)
    else $error("name state not cleared after final character");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !char_i.ready)
    else $error("character taken while result stalled");

  a_none_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.is_none |-> result_q.plain_length == 10'd4)
    else $error("is_none set with plain length other than four");

  a_prefix_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_none_q |-> none_match_q == 3'd4)
    else $error("prefix flag without full match");

endmodule

`default_nettype wire
